@@ hdl/brb_pkg.sv @@
// Package with commands, status codes and sizes for the byte ring buffer.
`timescale 1ns / 1ps
package brb_pkg;
    localparam int DEPTH_DEFAULT = 64;
    localparam int MAX_PATTERN_DEFAULT = 8;
    localparam int MAX_RESULTS = 64;

    localparam logic [2:0] CMD_PUSH    = 3'd0;
    localparam logic [2:0] CMD_POP     = 3'd1;
    localparam logic [2:0] CMD_EXTRACT = 3'd2;
    localparam logic [2:0] CMD_SKIP    = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_EMPTY      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_INCOMPLETE = 3'd4;

    localparam logic [1:0] REG_LABEL_PAT = 2'd0;
    localparam logic [1:0] REG_LABEL_LEN = 2'd1;
    localparam logic [1:0] REG_LIM_PAT   = 2'd2;
    localparam logic [1:0] REG_LIM_LEN   = 2'd3;

    // Result beat as it leaves the block.
    typedef struct packed {
        logic       is_full;
        logic       is_empty;
        logic       last;
        logic [2:0] status;
        logic [7:0] data;
    } result_t;
endpackage

@@ hdl/brb_ram.sv @@
// Byte store of the ring: one write port, one registered read port.
`timescale 1ns / 1ps
module brb_ram
    import brb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hdl/byte_ring_buffer_label_extract.sv @@
// Top level: byte ring buffer with label search and value extraction.
//
// Commands arrive on the s_axis channel (tdata: command, data_in). Each command
// produces result beats on m_axis (tdata: data_out, status, is_empty, is_full).
// The final beat of a command raises tlast. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while the block is
// idle, as the block does not enforce this. Push, pop, clear and unknown codes
// pass through the idle and single-result states. The command is taken while
// idle, which also issues the store read. The result enters the output register
// from the single-result state once that register is free. A new command can
// be taken straight after. Extract and skip walk the stored bytes one per cycle
// through the single read port: first the label scan, then at once the limiter
// scan. A search that runs out of bytes reports a failure. Extract then reads
// the value out at one beat per cycle unless stalled. A stalled receiver holds
// the output register. The sequencer waits in whichever state has the next beat
// ready, and takes no new command meanwhile. Reset empties the ring (head and
// tail to zero), restores lengths to one and patterns to zero. The store itself
// is not cleared, since only written entries are ever read.
`timescale 1ns / 1ps
module byte_ring_buffer_label_extract
    import brb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // command[2:0], data_in[10:3], zeros
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // data_out[7:0], status[10:8], is_empty[11],
                                        // is_full[12], zeros
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    localparam int AW = $clog2(DEPTH);

    logic        ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_wdata, ram_rdata;

    brb_ram #(.DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    brb_ctrl #(.DEPTH(DEPTH), .MAX_PATTERN(MAX_PATTERN)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
        .ram_raddr(ram_raddr), .ram_rdata(ram_rdata)
    );
endmodule

@@ hdl/brb_ctrl.sv @@
// Command sequencer: pointers, pattern matchers and the output register.
`timescale 1ns / 1ps
module brb_ctrl
    import brb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [15:0]              s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [15:0]              m_axis_tdata,
    output logic                     m_axis_tlast,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [63:0]              cfg_data,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output logic [7:0]               ram_wdata,
    output logic [$clog2(DEPTH)-1:0] ram_raddr,
    input  logic [7:0]               ram_rdata
);
    localparam int AW = $clog2(DEPTH);
    localparam int AW1 = AW + 1;
    localparam int PW = $clog2(MAX_PATTERN);
    localparam int LW = (PW > 0) ? PW : 1;
    localparam int HW = MAX_PATTERN * 8;
    localparam int RW = $clog2(MAX_RESULTS + 1);
    localparam int VW = (AW > RW) ? AW : RW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ONE   = 3'd1;   // single-result commands
    localparam logic [2:0] S_LABEL = 3'd2;
    localparam logic [2:0] S_LIM   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [2:0]    cmd_reg;
    logic [7:0]    data_reg;
    logic [63:0]   lab_pat_reg, lim_pat_reg;
    logic [3:0]    lab_len_reg, lim_len_reg;
    logic [AW-1:0] idx_reg, idx_next;      // scan position of the byte in ram_rdata
    logic [AW-1:0] n_reg, n_next;          // bytes available in the scan
    logic [AW-1:0] base_reg, base_next;    // first byte of the scan
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [HW-1:0] hist_reg, hist_next;    // recent bytes, newest at top
    logic [VW-1:0] vlen_reg, vlen_next;
    logic [VW-1:0] ecnt_reg, ecnt_next;
    logic          ovalid_reg;
    result_t       out_reg;
    logic          out_load;
    result_t       out_new;

    logic [LW-1:0] llen_m1, mlen_m1;
    logic [2:0]    in_cmd;
    logic          out_free;
    logic          hit;
    logic          suffix_ok;
    logic [AW-1:0] idx_inc;
    logic [VW-1:0] vraw;
    logic [VW-1:0] ecnt_inc;
    logic [HW+7:0] hist_cat;
    logic [HW-1:0] hist_shift;

    function automatic logic [LW-1:0] eff_m1(input logic [3:0] len);
        logic [3:0] v;
        v = (len == 4'd0) ? 4'd1 : len;
        if (v > 4'(MAX_PATTERN))
        begin
            v = 4'(MAX_PATTERN);
        end
        return LW'(v - 4'd1);
    endfunction

    function automatic logic [7:0] pbyte(input logic [63:0] p, input logic [LW-1:0] k);
        return p[{3'(k), 3'd0} +: 8];
    endfunction

    // Ring addition of two indexes that are each below DEPTH.
    function automatic logic [AW-1:0] wadd(input logic [AW-1:0] a, input logic [AW-1:0] c);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, c};
        if (s >= AW1'(DEPTH))
        begin
            s = s - AW1'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wsub(input logic [AW-1:0] a, input logic [AW-1:0] c);
        logic [AW:0] s;
        if (a >= c)
        begin
            s = {1'b0, a} - {1'b0, c};
        end
        else
        begin
            s = {1'b0, a} + AW1'(DEPTH) - {1'b0, c};
        end
        return s[AW-1:0];
    endfunction

    assign llen_m1 = eff_m1(lab_len_reg);
    assign mlen_m1 = eff_m1(lim_len_reg);
    assign in_cmd  = s_axis_tdata[2:0];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {3'd0, out_reg.is_full, out_reg.is_empty, out_reg.status,
                            out_reg.data};
    assign m_axis_tlast  = out_reg.last;
    assign out_free      = !ovalid_reg || m_axis_tready;

    assign idx_inc    = AW'(idx_reg + AW'(1));
    assign vraw       = VW'(idx_reg) - VW'(mlen_m1);
    assign ecnt_inc   = VW'(ecnt_reg + VW'(1));
    assign hist_cat   = {ram_rdata, hist_reg};
    assign hist_shift = hist_cat[HW+7:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lab_pat_reg <= '0;
            lim_pat_reg <= '0;
            lab_len_reg <= 4'd1;
            lim_len_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LABEL_PAT: lab_pat_reg <= cfg_data;
                REG_LABEL_LEN: lab_len_reg <= cfg_data[3:0];
                REG_LIM_PAT:   lim_pat_reg <= cfg_data;
                REG_LIM_LEN:   lim_len_reg <= cfg_data[3:0];
                default:       ;
            endcase
        end
    end

    // Byte t back from the newest lines up with limiter byte mlen-1-t.
    always_comb
    begin
        suffix_ok = 1'b1;
        for (int t = 0; t < MAX_PATTERN; t++)
        begin
            if ((LW'(t) <= mlen_m1)
                && (hist_shift[HW-1-8*t -: 8] != pbyte(lim_pat_reg, LW'(int'(mlen_m1) - t))))
            begin
                suffix_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        hist_next  = hist_reg;
        vlen_next  = vlen_reg;
        ecnt_next  = ecnt_reg;
        ram_we     = 1'b0;
        ram_waddr  = head_reg;
        ram_wdata  = data_reg;
        ram_raddr  = wadd(base_reg, idx_reg);
        out_load   = 1'b0;
        out_new    = '0;
        hit        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = tail_reg;
                if (s_axis_tvalid)
                begin
                    idx_next  = '0;
                    n_next    = wsub(head_reg, tail_reg);
                    base_next = tail_reg;
                    cnt_next  = '0;
                    hist_next = '0;
                    if (in_cmd == CMD_EXTRACT || in_cmd == CMD_SKIP)
                    begin
                        state_next = S_LABEL;
                    end
                    else
                    begin
                        state_next = S_ONE;
                    end
                end
            end
            S_ONE:
            begin
                // Keep reading the tail so a stalled pop still sees its byte.
                ram_raddr = tail_reg;
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_new.last   = 1'b1;
                    out_new.status = ST_OK;
                    state_next     = S_IDLE;
                    unique case (cmd_reg)
                        CMD_PUSH:
                        begin
                            if (wadd(head_reg, AW'(1)) == tail_reg)
                            begin
                                out_new.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                head_next = wadd(head_reg, AW'(1));
                            end
                        end
                        CMD_POP:
                        begin
                            if (head_reg == tail_reg)
                            begin
                                out_new.status = ST_EMPTY;
                            end
                            else
                            begin
                                out_new.data = ram_rdata;
                                tail_next    = wadd(tail_reg, AW'(1));
                            end
                        end
                        CMD_CLEAR:
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_LABEL:
            begin
                if (idx_reg == n_reg)
                begin
                    if (out_free)
                    begin
                        out_load       = 1'b1;
                        out_new.last   = 1'b1;
                        out_new.status = ST_NOT_FOUND;
                        state_next     = S_IDLE;
                    end
                end
                else if (ram_rdata == pbyte(lab_pat_reg, cnt_reg) && cnt_reg == llen_m1)
                begin
                    // The value starts right after the last label byte.
                    state_next = S_LIM;
                    base_next  = wadd(base_reg, idx_inc);
                    n_next     = AW'(n_reg - idx_inc);
                    idx_next   = '0;
                    cnt_next   = '0;
                    ram_raddr  = wadd(base_reg, idx_inc);
                end
                else
                begin
                    if (ram_rdata == pbyte(lab_pat_reg, cnt_reg))
                    begin
                        cnt_next = LW'(cnt_reg + LW'(1));
                    end
                    else
                    begin
                        cnt_next = '0;
                    end
                    idx_next  = idx_inc;
                    ram_raddr = wadd(base_reg, idx_inc);
                end
            end
            S_LIM:
            begin
                if (idx_reg == n_reg)
                begin
                    if (out_free)
                    begin
                        out_load       = 1'b1;
                        out_new.last   = 1'b1;
                        out_new.status = ST_INCOMPLETE;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    if (cmd_reg == CMD_SKIP)
                    begin
                        hit = (ram_rdata == pbyte(lim_pat_reg, cnt_reg)) && (cnt_reg == mlen_m1);
                    end
                    else
                    begin
                        hit = (VW'(idx_reg) >= VW'(mlen_m1)) && suffix_ok;
                    end

                    if (hit && cmd_reg != CMD_SKIP && vraw != '0)
                    begin
                        tail_next  = wadd(base_reg, idx_inc);
                        vlen_next  = (vraw > VW'(MAX_RESULTS)) ? VW'(MAX_RESULTS) : vraw;
                        ecnt_next  = '0;
                        ram_raddr  = base_reg;
                        state_next = S_EMIT;
                    end
                    else if (hit)
                    begin
                        // Skip, or extract with an empty value: one beat.
                        if (out_free)
                        begin
                            tail_next    = wadd(base_reg, idx_inc);
                            out_load     = 1'b1;
                            out_new.last = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    else
                    begin
                        hist_next = hist_shift;
                        if (ram_rdata == pbyte(lim_pat_reg, cnt_reg))
                        begin
                            cnt_next = LW'(cnt_reg + LW'(1));
                        end
                        else
                        begin
                            cnt_next = '0;
                        end
                        idx_next  = idx_inc;
                        ram_raddr = wadd(base_reg, idx_inc);
                    end
                end
            end
            S_EMIT:
            begin
                // ram_rdata holds value byte ecnt_reg.
                if (out_free)
                begin
                    out_load     = 1'b1;
                    out_new.data = ram_rdata;
                    out_new.last = (ecnt_inc == vlen_reg);
                    ecnt_next    = ecnt_inc;
                    ram_raddr    = wadd(base_reg, AW'(ecnt_inc));
                    if (ecnt_inc == vlen_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ram_raddr = wadd(base_reg, AW'(ecnt_reg));
                end
            end
            default: state_next = S_IDLE;
        endcase
        // Flags reflect the pointers as they stand after this command.
        out_new.is_empty = (head_next == tail_next);
        out_new.is_full  = (wadd(head_next, AW'(1)) == tail_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            if (out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        n_reg    <= n_next;
        base_reg <= base_next;
        cnt_reg  <= cnt_next;
        hist_reg <= hist_next;
        vlen_reg <= vlen_next;
        ecnt_reg <= ecnt_next;
        if (out_load)
        begin
            out_reg <= out_new;
        end
        if (state_reg == S_IDLE)
        begin
            cmd_reg  <= in_cmd;
            data_reg <= s_axis_tdata[10:3];
        end
    end
endmodule
